[sv/xent_pkg.sv]
// Shared types, constants and the log table for the cross-entropy loss core.
`default_nettype none
package xent_pkg;

	// Field and datapath widths
	localparam int PROB_W   = 16;
	localparam int GRAD_W   = 32;
	localparam int LOSS_W   = 31;
	localparam int NCFG_W   = 17;
	localparam int CCFG_W   = 9;
	localparam int SUM_W    = 48;
	localparam int LN_W     = 30;
	localparam int PROD_W   = 48;
	localparam int TERM_W   = 50;
	localparam int NUM_W    = 56;
	localparam int DEN_W    = 45;
	localparam int CFG_IDX_W = 2;

	// Log table geometry
	localparam int LN_DEPTH = 1024;
	localparam int LN_BITS  = $clog2(LN_DEPTH);

	// Fixed-point constants
	localparam logic [PROB_W-1:0] CLAMP_LO = 16'd3277;
	localparam logic [PROB_W-1:0] CLAMP_HI = 16'd29491;
	localparam logic [PROB_W:0]   ONE_Q15  = 17'd32768;
	localparam logic [23:0]       LN2_Q24  = 24'd11629080;
	localparam logic [63:0]       LN2_Q32  = 64'd2977044472;
	localparam logic [NCFG_W-1:0] N_MAX    = 17'd65536;
	localparam logic [CCFG_W-1:0] C_MAX    = 9'd256;
	localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

	typedef logic [23:0] ln_tbl_t [0:LN_DEPTH];

	// ln(1 + k/LN_DEPTH) in Q.24, log2 by repeated squaring times ln2
	function automatic logic [23:0] ln_point(int unsigned k);
		logic [63:0] v;
		logic [63:0] lg;
		logic [63:0] t;
		int i;
		if (k >= LN_DEPTH) return LN2_Q24;
		v = (64'(LN_DEPTH + k) << 30) >> LN_BITS;
		lg = '0;
		for (i = 0; i < 24; i++) begin
			v = (v * v) >> 30;
			lg = lg << 1;
			if (v >= (64'd2 << 30)) begin
				v = v >> 1;
				lg = lg | 64'd1;
			end
		end
		t = (lg * LN2_Q32 + (64'd1 << 31)) >> 32;
		return t[23:0];
	endfunction

	function automatic ln_tbl_t build_ln_tbl();
		ln_tbl_t t;
		for (int k = 0; k <= LN_DEPTH; k++) t[k] = ln_point(k);
		return t;
	endfunction

	localparam ln_tbl_t LN_TBL = build_ln_tbl();

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		ST_NONE,
		ST_LOAD,
		ST_LN_A,
		ST_LN_B,
		ST_LN_C,
		ST_LN_D,
		ST_TERM_A,
		ST_TERM_B,
		ST_SUM,
		ST_DEN_A,
		ST_DEN_B,
		ST_GRAD_GO,
		ST_GRAD_END,
		ST_MEAN_GO,
		ST_MEAN_END,
		ST_OUT
	} step_t;

	typedef struct packed {
		step_t step;
		logic  ln_sel;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic mode;
		logic last;
		logic sum_pos;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

[sv/xent_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module xent_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [xent_pkg::NUM_W-1:0] num,
	input  wire logic [xent_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic [xent_pkg::NUM_W-1:0]     quo
);
	import xent_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift in the next numerator bit and try the subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control: count steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

[sv/xent_dp.sv]
// Datapath: config registers, clamp, log unit, loss sum, gradient and output register.
`default_nettype none
module xent_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [xent_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [xent_pkg::NCFG_W-1:0]   cfg_wdata,
	input  wire logic [63:0]                   s_tdata,
	input  wire logic                          s_tlast,
	input  wire xent_pkg::cmd_t                cmd,
	output xent_pkg::status_t                  status,
	output logic [63:0]                        m_tdata,
	output logic                               m_tuser
);
	import xent_pkg::*;

	localparam logic signed [TERM_W-1:0] SUM_HI =
		$signed({{(TERM_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}});
	localparam logic signed [TERM_W-1:0] SUM_LO = -SUM_HI - TERM_W'(1);
	localparam logic signed [GRAD_W+25:0] GRAD_HI = (GRAD_W+26)'(32'sh7fffffff);
	localparam logic signed [GRAD_W+25:0] GRAD_LO = -GRAD_HI - (GRAD_W+26)'(1);

	// Configuration
	logic              mode_q;
	logic [NCFG_W-1:0] ecount_q;
	logic [CCFG_W-1:0] ccount_q;
	logic [NCFG_W-1:0] n_eff;
	logic [CCFG_W-1:0] c_eff;

	// Item registers
	logic [PROB_W-1:0]        xc_q;
	logic [PROB_W-1:0]        om_q;
	logic [PROB_W-1:0]        g_q;
	logic signed [GRAD_W-1:0] prior_q;
	logic                     last_q;
	logic                     skip_q;

	// Log unit registers
	logic [3:0]         e_q;
	logic [LN_BITS-1:0] k_q;
	logic [14:0]        frac_q;
	logic [23:0]        l0_q;
	logic [23:0]        l1_q;
	logic [23:0]        dr_q;
	logic signed [LN_W-1:0] lx_q;
	logic signed [LN_W-1:0] l1x_q;

	// Loss and gradient registers
	logic signed [PROD_W-1:0] p1_q;
	logic signed [PROD_W-1:0] p2_q;
	logic signed [SUM_W-1:0]  loss_sum_q;
	logic [31:0]              m1_q;
	logic [DEN_W-1:0]         den_q;
	logic                     dneg_q;
	logic signed [GRAD_W-1:0] grad_q;
	logic [LOSS_W-1:0]        loss_q;
	logic [63:0]              m_tdata_q;
	logic                     m_tuser_q;

	// Divider hookup
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	// Combinational intermediates
	logic [PROB_W-1:0]        prob;
	logic [PROB_W-1:0]        xc;
	logic [PROB_W-1:0]        ln_v;
	logic [3:0]               ln_e;
	logic [14:0]              ln_f;
	logic [14+LN_BITS:0]      ln_num;
	logic [LN_BITS-1:0]       ln_k;
	logic [14+LN_BITS:0]      ln_rem;
	logic [23:0]              ln_diff;
	logic [38:0]              ln_prod;
	logic signed [4:0]        ln_es;
	logic signed [LN_W-1:0]   ln_val;
	logic signed [PROB_W:0]   gs;
	logic signed [PROB_W+1:0] omg;
	logic signed [TERM_W-1:0] tsum;
	logic [TERM_W-1:0]        tmag;
	logic [TERM_W-1:0]        trnd;
	logic signed [TERM_W-1:0] term;
	logic signed [TERM_W-1:0] sum_new;
	logic signed [PROB_W:0]   xmg;
	logic [PROB_W-1:0]        xmg_mag;
	logic [NUM_W-1:0]         gnum;
	logic [NUM_W-1:0]         mnum;
	logic [25:0]              nc;
	logic [DEN_W-1:0]         mden;
	logic signed [NUM_W:0]    delta;
	logic signed [GRAD_W+25:0] gsum;

	// Clamp the register values to their working range
	always_comb begin
		n_eff = ecount_q;
		if (ecount_q == '0) n_eff = NCFG_W'(1);
		else if (ecount_q > N_MAX) n_eff = N_MAX;
		c_eff = ccount_q;
		if (ccount_q == '0) c_eff = CCFG_W'(1);
		else if (ccount_q > C_MAX) c_eff = C_MAX;
	end

	// Clamp the incoming prediction
	assign prob = s_tdata[15:0];
	always_comb begin
		xc = (prob < CLAMP_LO) ? CLAMP_LO : prob;
		if (!mode_q && xc > CLAMP_HI) xc = CLAMP_HI;
	end

	// Log unit: split operand into exponent, table index and fraction
	assign ln_v = cmd.ln_sel ? om_q : xc_q;
	always_comb begin
		ln_e = '0;
		for (int i = 0; i < PROB_W; i++) begin
			if (ln_v[i]) ln_e = 4'(i);
		end
	end
	assign ln_f    = 15'(ln_v - (16'd1 << ln_e));
	assign ln_num  = {ln_f, {LN_BITS{1'b0}}};
	assign ln_k    = LN_BITS'(ln_num >> ln_e);
	assign ln_rem  = ln_num - ((15+LN_BITS)'(ln_k) << ln_e);
	assign ln_diff = (l1_q > l0_q) ? (l1_q - l0_q) : '0;
	assign ln_prod = (39'(ln_diff) * 39'(frac_q)) >> e_q;
	assign ln_es   = $signed({1'b0, e_q}) - 5'sd15;
	assign ln_val  = LN_W'(ln_es * $signed({1'b0, LN2_Q24}))
		+ $signed(LN_W'(l0_q)) + $signed(LN_W'(dr_q));

	// Loss term, rounded division by 2^15
	assign gs   = $signed({1'b0, g_q});
	assign omg  = $signed({1'b0, ONE_Q15}) - (PROB_W+2)'(gs);
	assign tsum = -(TERM_W'(p1_q) + TERM_W'(p2_q));
	assign tmag = tsum[TERM_W-1] ? TERM_W'(-tsum) : TERM_W'(tsum);
	assign trnd = (tmag + TERM_W'(16384)) >> 15;
	assign term = tsum[TERM_W-1] ? -$signed(trnd) : $signed(trnd);
	always_comb begin
		sum_new = TERM_W'(loss_sum_q) + term;
		if (sum_new > SUM_HI) sum_new = SUM_HI;
		else if (sum_new < SUM_LO) sum_new = SUM_LO;
	end

	// Divider operands, with half the divisor added for rounding
	assign xmg     = $signed({1'b0, xc_q}) - gs;
	assign xmg_mag = xmg[PROB_W] ? PROB_W'(-xmg) : PROB_W'(xmg);
	assign gnum    = mode_q ? (NUM_W'(g_q) << 24) : (NUM_W'(xmg_mag) << 39);
	assign nc      = 26'(n_eff) * 26'(c_eff);
	assign mden    = mode_q ? DEN_W'(nc) : DEN_W'(n_eff);
	assign mnum    = NUM_W'(loss_sum_q);
	assign div_start = (cmd.step == ST_GRAD_GO) || (cmd.step == ST_MEAN_GO);
	assign div_den   = (cmd.step == ST_MEAN_GO) ? mden : den_q;
	assign div_num   = ((cmd.step == ST_MEAN_GO) ? mnum : gnum) + NUM_W'(div_den >> 1);

	// Signed delta and saturated gradient
	assign delta = dneg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	always_comb begin
		gsum = (GRAD_W+26)'(prior_q) + (GRAD_W+26)'(delta);
		if (gsum > GRAD_HI) gsum = GRAD_HI;
		else if (gsum < GRAD_LO) gsum = GRAD_LO;
	end

	xent_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Config registers and the loss sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			ecount_q   <= NCFG_W'(1);
			ccount_q   <= CCFG_W'(1);
			loss_sum_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:     mode_q   <= cfg_wdata[0];
					CFG_ELEMENTS: ecount_q <= cfg_wdata;
					CFG_CHANNELS: ccount_q <= cfg_wdata[CCFG_W-1:0];
					default:      ;
				endcase
			end
			if (cmd.step == ST_SUM) loss_sum_q <= SUM_W'(sum_new);
			else if (cmd.step == ST_OUT && last_q) loss_sum_q <= '0;
		end
	end

	// Payload registers, one operation per controller step
	always_ff @(posedge clk) begin
		case (cmd.step)
			ST_LOAD: begin
				xc_q    <= xc;
				om_q    <= PROB_W'(ONE_Q15 - 17'(xc));
				g_q     <= s_tdata[31:16];
				prior_q <= $signed(s_tdata[63:32]);
				last_q  <= s_tlast;
				skip_q  <= prob == s_tdata[31:16];
				grad_q  <= $signed(s_tdata[63:32]);
				loss_q  <= '0;
			end
			ST_LN_A: begin
				e_q    <= ln_e;
				k_q    <= ln_k;
				frac_q <= 15'(ln_rem);
			end
			ST_LN_B: begin
				l0_q <= LN_TBL[{1'b0, k_q}];
				l1_q <= LN_TBL[{1'b0, k_q} + (LN_BITS+1)'(1)];
			end
			ST_LN_C: dr_q <= ln_prod[23:0];
			ST_LN_D: begin
				if (cmd.ln_sel) l1x_q <= ln_val;
				else lx_q <= ln_val;
			end
			ST_TERM_A: p1_q <= PROD_W'(gs * lx_q);
			ST_TERM_B: p2_q <= mode_q ? '0 : PROD_W'(omg * l1x_q);
			ST_DEN_A: m1_q <= mode_q ? 32'(xc_q) * 32'(c_eff) : 32'(xc_q) * 32'(om_q);
			ST_DEN_B: den_q <= DEN_W'(49'(m1_q) * 49'(n_eff));
			ST_GRAD_GO: dneg_q <= mode_q ? 1'b1 : xmg[PROB_W];
			ST_GRAD_END: grad_q <= GRAD_W'(gsum);
			ST_MEAN_END: loss_q <= (div_quo > NUM_W'(LOSS_MAX)) ? LOSS_MAX : div_quo[LOSS_W-1:0];
			ST_OUT: begin
				m_tdata_q <= {1'b0, loss_q, grad_q};
				m_tuser_q <= last_q;
			end
			default: ;
		endcase
	end

	assign status.skip     = skip_q;
	assign status.mode     = mode_q;
	assign status.last     = last_q;
	assign status.sum_pos  = loss_sum_q > 0;
	assign status.div_done = div_done;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
`default_nettype wire

[sv/xent_ctrl.sv]
// Controller: sequences one element through the datapath and owns the handshakes.
`default_nettype none
module xent_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	input  wire xent_pkg::status_t  status,
	output xent_pkg::cmd_t          cmd
);
	import xent_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_LN_A, S_LN_B, S_LN_C, S_LN_D, S_TERM_A, S_TERM_B, S_SUM,
		S_DEN_A, S_DEN_B, S_GRAD_GO, S_GRAD_WAIT, S_GRAD_END, S_LAST,
		S_MEAN_GO, S_MEAN_WAIT, S_MEAN_END, S_OUT
	} state_t;

	state_t state_q;
	logic   ln_sel_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = state_q == S_IDLE;
	assign out_free = !m_tvalid_q || m_tready;

	// Decode the datapath step for the current state
	always_comb begin
		cmd.ln_sel = ln_sel_q;
		unique case (state_q)
			S_IDLE:      cmd.step = s_tvalid ? ST_LOAD : ST_NONE;
			S_LN_A:      cmd.step = ST_LN_A;
			S_LN_B:      cmd.step = ST_LN_B;
			S_LN_C:      cmd.step = ST_LN_C;
			S_LN_D:      cmd.step = ST_LN_D;
			S_TERM_A:    cmd.step = ST_TERM_A;
			S_TERM_B:    cmd.step = ST_TERM_B;
			S_SUM:       cmd.step = ST_SUM;
			S_DEN_A:     cmd.step = ST_DEN_A;
			S_DEN_B:     cmd.step = ST_DEN_B;
			S_GRAD_GO:   cmd.step = ST_GRAD_GO;
			S_GRAD_END:  cmd.step = ST_GRAD_END;
			S_MEAN_GO:   cmd.step = ST_MEAN_GO;
			S_MEAN_END:  cmd.step = ST_MEAN_END;
			S_OUT:       cmd.step = out_free ? ST_OUT : ST_NONE;
			default:     cmd.step = ST_NONE;
		endcase
	end

	// State, log operand select and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ln_sel_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop valid once the beat is taken, unless a new beat loads now
			if (m_tvalid_q && m_tready && state_q != S_OUT) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_CHK;
				S_CHK: begin
					ln_sel_q <= 1'b0;
					state_q  <= status.skip ? S_LAST : S_LN_A;
				end
				S_LN_A: state_q <= S_LN_B;
				S_LN_B: state_q <= S_LN_C;
				S_LN_C: state_q <= S_LN_D;
				S_LN_D: begin
					// sigmoid needs a second log, of one minus the prediction
					if (!ln_sel_q && !status.mode) begin
						ln_sel_q <= 1'b1;
						state_q  <= S_LN_A;
					end else begin
						state_q <= S_TERM_A;
					end
				end
				S_TERM_A:    state_q <= S_TERM_B;
				S_TERM_B:    state_q <= S_SUM;
				S_SUM:       state_q <= S_DEN_A;
				S_DEN_A:     state_q <= S_DEN_B;
				S_DEN_B:     state_q <= S_GRAD_GO;
				S_GRAD_GO:   state_q <= S_GRAD_WAIT;
				S_GRAD_WAIT: if (status.div_done) state_q <= S_GRAD_END;
				S_GRAD_END:  state_q <= S_LAST;
				S_LAST: state_q <= (status.last && status.sum_pos) ? S_MEAN_GO : S_OUT;
				S_MEAN_GO:   state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: if (status.div_done) state_q <= S_MEAN_END;
				S_MEAN_END:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

[sv/cross_entropy_loss_and_gradient_core.sv]
// Top level: cross-entropy loss and gradient core, one element at a time.
// One element is in work at a time; a skipped element (prediction equal to truth) bypasses
// the log and gradient steps, and sigmoid mode runs the log unit twice. A last element
// with a positive loss sum adds a mean loss division on the shared 56-step restoring divider,
// which also computes the gradient.
// A finished beat waits in the output register while the next element is accepted.
// Reset clears the loss sum and sets mode 0, element count 1, channel count 1.
`default_nettype none
module cross_entropy_loss_and_gradient_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // prob[15:0], truth[31:16], prior_gradient[63:32]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // gradient[31:0], loss[62:32], zero[63]
	output logic             m_tuser    // loss_valid[0]
);
	import xent_pkg::*;

	cmd_t    cmd;
	status_t status;

	xent_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	xent_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for the cross-entropy loss and gradient core: predicted stream check.
`timescale 1ns / 100ps
module tb;
	import xent_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [15:0] prob;
		logic [15:0] truth;
		logic [31:0] prior;
		logic        last;
	} elem_t;

	typedef struct {
		logic [31:0] grad;
		logic [30:0] loss;
		logic        loss_valid;
	} grad_loss_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	cross_entropy_loss_and_gradient_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	elem_t      pend_q[$];
	grad_loss_t exp_q[$];
	longint     ln_tab[0:1024];
	longint     loss_acc;
	logic       mode_r;
	logic [16:0] n_r;
	logic [8:0] c_r;
	int         errors = 0;
	int         cycles = 0;
	int         in_acc = 0, drv_cnt = 0, out_acc = 0, mon_seen = 0;
	int         drv_gap = 0, mon_stall = 0;
	bit         drv_quiet = 0, mon_quiet = 0;

	// round to nearest, halves away from zero
	function automatic longint round_div(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// ln(1 + k/1024) in Q.24 via log2 by repeated squaring
	function automatic longint ln_entry(int k);
		bit [63:0] v, lg;
		if (k >= 1024) return 64'd11629080;
		v = ((64'(1024 + k)) << 30) / 64'd1024;
		lg = '0;
		for (int i = 0; i < 24; i++) begin
			v = (v * v) >> 30;
			lg = lg << 1;
			if (v >= (64'd2 << 30)) begin
				v = v >> 1;
				lg = lg | 64'd1;
			end
		end
		return longint'((lg * 64'd2977044472 + (64'd1 << 31)) >> 32);
	endfunction

	// natural log of v/32768 in Q.24
	function automatic longint ln_fix(int unsigned v);
		int e;
		longint f, num, k, rem, l0, l1, diff;
		if (v == 0) v = 1;
		e = 15;
		while (e > 0 && !v[e]) e--;
		f = longint'(v) - (longint'(1) << e);
		num = f * 1024;
		k = num >> e;
		rem = num - (k << e);
		l0 = ln_tab[k];
		l1 = ln_tab[(k + 1 > 1024) ? 1024 : k + 1];
		diff = (l1 > l0) ? l1 - l0 : 0;
		return longint'(e - 15) * 11629080 + l0 + ((diff * rem) >> e);
	endfunction

	// compute the output beat for one element and update the loss sum
	function automatic grad_loss_t predict_grad_loss(elem_t it);
		grad_loss_t r;
		longint n, c, g, x, term, delta, grad, loss;
		n = n_r;
		c = c_r;
		if (n < 1) n = 1;
		if (n > 65536) n = 65536;
		if (c < 1) c = 1;
		if (c > 256) c = 256;
		g = it.truth;
		grad = longint'(signed'(it.prior));
		loss = 0;
		if (it.prob != it.truth) begin
			x = (it.prob < CLAMP_LO) ? longint'(CLAMP_LO) : longint'(it.prob);
			if (!mode_r) begin
				if (x > CLAMP_HI) x = CLAMP_HI;
				term = round_div(-(g * ln_fix(x) + (32768 - g) * ln_fix(32768 - x)), 32768);
				delta = round_div((x - g) * (longint'(1) << 39), x * (32768 - x) * n);
			end else begin
				term = round_div(-(g * ln_fix(x)), 32768);
				delta = -round_div(g * (longint'(1) << 24), x * n * c);
			end
			loss_acc += term;
			if (loss_acc > 64'sd140737488355327) loss_acc = 64'sd140737488355327;
			if (loss_acc < -64'sd140737488355328) loss_acc = -64'sd140737488355328;
			grad = grad + delta;
			if (grad > 64'sd2147483647) grad = 64'sd2147483647;
			if (grad < -64'sd2147483648) grad = -64'sd2147483648;
		end
		if (it.last) begin
			if (loss_acc > 0) loss = round_div(loss_acc, mode_r ? n * c : n);
			if (loss > 64'sd2147483647) loss = 64'sd2147483647;
			loss_acc = 0;
		end
		r.grad = grad[31:0];
		r.loss = loss[30:0];
		r.loss_valid = it.last;
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// record accepted input beats and predict their results
	always @(posedge clk) begin
		elem_t it;
		if (arst_n && s_tvalid && s_tready) begin
			it.prob = s_tdata[15:0];
			it.truth = s_tdata[31:16];
			it.prior = s_tdata[63:32];
			it.last = s_tlast;
			exp_q.push_back(predict_grad_loss(it));
			in_acc <= in_acc + 1;
		end
	end

	// check accepted output beats against the oldest prediction
	always @(posedge clk) begin
		grad_loss_t e;
		if (arst_n && m_tvalid && m_tready) begin
			out_acc <= out_acc + 1;
			if (exp_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output beat: %h user %b", m_tdata, m_tuser);
			end else begin
				e = exp_q.pop_front();
				if (m_tdata[31:0] !== e.grad || m_tdata[62:32] !== e.loss
						|| m_tuser !== e.loss_valid) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: grad exp %h got %h, loss exp %h got %h, valid exp %b got %b",
							e.grad, m_tdata[31:0], e.loss, m_tdata[62:32], e.loss_valid, m_tuser);
				end
			end
		end
	end

	// input driver: present one beat per pending element, with random gaps
	always @(negedge clk) begin
		logic nv;
		elem_t it;
		nv = s_tvalid;
		if (s_tvalid && in_acc == drv_cnt) begin
			nv = 1'b0;
			drv_gap = drv_quiet ? 0 : $urandom_range(0, 14);
		end
		if (!nv && arst_n) begin
			if (drv_gap > 0) begin
				drv_gap--;
			end else if (pend_q.size() > 0) begin
				it = pend_q.pop_front();
				s_tdata <= {it.prior, it.truth, it.prob};
				s_tlast <= it.last;
				nv = 1'b1;
				drv_cnt++;
			end
		end
		s_tvalid <= nv;
	end

	// output ready: stall a random number of cycles after each beat
	always @(negedge clk) begin
		if (out_acc != mon_seen) begin
			mon_seen = out_acc;
			mon_stall = mon_quiet ? 0 : $urandom_range(0, 14);
		end
		if (mon_stall > 0) begin
			m_tready <= 1'b0;
			mon_stall--;
		end else begin
			m_tready <= arst_n;
		end
	end

	task automatic add_elem(input logic [15:0] p, input logic [15:0] t,
			input logic [31:0] g, input logic l);
		elem_t it;
		it.prob = p;
		it.truth = t;
		it.prior = g;
		it.last = l;
		pend_q.push_back(it);
	endtask

	// hold until every beat is through and the core has settled
	task automatic wait_drain();
		while (pend_q.size() > 0 || s_tvalid || exp_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE) mode_r = val[0];
		else if (idx == CFG_ELEMENTS) n_r = val;
		else if (idx == CFG_CHANNELS) c_r = val[8:0];
	endtask

	// random tensors, mostly in-range probabilities
	task automatic random_phase(input int count);
		int left, len;
		bit heavy;
		logic [15:0] p, t;
		logic [31:0] g;
		left = count;
		drv_quiet = ($urandom_range(0, 3) == 0);
		mon_quiet = ($urandom_range(0, 3) == 0);
		while (left > 0) begin
			heavy = ($urandom_range(0, 9) == 0);
			len = heavy ? 40 : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0: p = 16'($urandom);
					1: p = 16'($urandom_range(0, 3400));
					2: p = 16'($urandom_range(29400, 32768));
					default: p = 16'($urandom_range(0, 32768));
				endcase
				case ($urandom_range(0, 9))
					0: t = p;
					1: t = 16'($urandom);
					2: t = 16'd0;
					3: t = 16'd32768;
					default: t = 16'($urandom_range(0, 32768));
				endcase
				if (heavy) begin
					p = 16'($urandom_range(0, 3277));
					t = 16'hFFFF;
				end
				case ($urandom_range(0, 7))
					0: g = 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
					1: g = 32'h8000_0000 + $urandom_range(0, 1 << 20);
					default: g = $urandom;
				endcase
				add_elem(p, t, g, i == len - 1);
				left--;
			end
		end
		wait_drain();
	endtask

	initial begin
		for (int k = 0; k <= 1024; k++) ln_tab[k] = ln_entry(k);
		mode_r = 1'b0;
		n_r = 17'd1;
		c_r = 9'd1;
		loss_acc = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, clamp edges, skips, saturation
		add_elem(16'd0, 16'd0, 32'h0000_0000, 1'b0);
		add_elem(16'd32768, 16'd0, 32'h7FFF_FFFF, 1'b0);
		add_elem(16'd0, 16'd32768, 32'h8000_0000, 1'b0);
		add_elem(16'd3276, 16'd16384, 32'h1234_5678, 1'b1);
		add_elem(16'd3277, 16'd16384, 32'hFFFF_FFFF, 1'b0);
		add_elem(16'd29491, 16'd100, 32'h7FFF_0000, 1'b0);
		add_elem(16'd29492, 16'd32768, 32'h8000_0001, 1'b0);
		add_elem(16'hFFFF, 16'd0, 32'h7FFF_FFFF, 1'b0);
		add_elem(16'd100, 16'hFFFF, 32'h0, 1'b1);
		add_elem(16'd5000, 16'd5000, 32'hDEAD_BEEF, 1'b1);
		add_elem(16'd0, 16'hFFFF, 32'h0, 1'b0);
		add_elem(16'd0, 16'hFFFF, 32'h0, 1'b1);
		wait_drain();
		write_reg(CFG_MODE, 17'd1);
		add_elem(16'd0, 16'hFFFF, 32'h8000_0000, 1'b0);
		add_elem(16'hFFFF, 16'd0, 32'h1, 1'b0);
		add_elem(16'd40000, 16'd65000, 32'h7FFF_FFFF, 1'b0);
		add_elem(16'd32768, 16'd32768, 32'h5555_AAAA, 1'b1);
		add_elem(16'd1000, 16'd32768, 32'h0, 1'b1);
		wait_drain();

		// setting sweep, extremes and out-of-range values included
		write_reg(CFG_MODE, 17'd0);
		random_phase(150);
		write_reg(CFG_ELEMENTS, 17'd65536);
		random_phase(120);
		write_reg(CFG_MODE, 17'd1);
		write_reg(CFG_CHANNELS, 17'd256);
		random_phase(120);
		write_reg(CFG_ELEMENTS, 17'd0);
		write_reg(CFG_CHANNELS, 17'd0);
		random_phase(120);
		write_reg(CFG_ELEMENTS, 17'h1FFFF);
		write_reg(CFG_CHANNELS, 17'h1FF);
		write_reg(2'd3, 17'h1ABCD);
		random_phase(120);
		write_reg(CFG_MODE, 17'h1FFFE);
		write_reg(CFG_ELEMENTS, 17'd1);
		write_reg(CFG_CHANNELS, 17'd1);
		random_phase(150);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_MODE, 17'($urandom_range(0, 1)));
			write_reg(CFG_ELEMENTS, 17'($urandom));
			write_reg(CFG_CHANNELS, 17'($urandom_range(0, 511)));
			random_phase(110);
		end

		wait_drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
sv/xent_pkg.sv
sv/xent_div.sv
sv/xent_dp.sv
sv/xent_ctrl.sv
sv/cross_entropy_loss_and_gradient_core.sv
dv/tb.sv
